### sv/scd_pkg.sv
// scd_pkg: shared constants, types and helpers for the serial command decoder
// no dependencies; used by the interfaces and every module of the block

package scd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CfgIdxW = 2;

  // parse phases
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_SKIP  = 3'd1;
  localparam logic [2:0] PH_X     = 3'd2;
  localparam logic [2:0] PH_Y     = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_OTHER = 3'd5;

  // characters
  localparam logic [ByteW-1:0] CHAR_C     = 8'h43;
  localparam logic [ByteW-1:0] CHAR_E     = 8'h45;
  localparam logic [ByteW-1:0] CHAR_R     = 8'h52;
  localparam logic [ByteW-1:0] CHAR_COLON = 8'h3A;
  localparam logic [ByteW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [ByteW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CHAR_NINE  = 8'h39;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_X_LO = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_X_HI = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_Y_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_Y_HI = 2'd3;

  // register reset values
  localparam logic [CoordW-1:0] X_LO_RST = 16'd2000;
  localparam logic [CoordW-1:0] X_HI_RST = 16'd15100;
  localparam logic [CoordW-1:0] Y_LO_RST = 16'd0;
  localparam logic [CoordW-1:0] Y_HI_RST = 16'hFFFF;

  typedef struct packed {
    logic [CoordW-1:0] x_lo;
    logic [CoordW-1:0] x_hi;
    logic [CoordW-1:0] y_lo;
    logic [CoordW-1:0] y_hi;
  } bounds_t;

  typedef struct packed {
    logic              enable_request;
    logic              reset_request;
    logic              coord_valid;
    logic [CoordW-1:0] x_target;
    logic [CoordW-1:0] y_target;
    logic              malformed;
  } result_t;

  function automatic logic [CoordW-1:0] clamp16(input logic [CoordW-1:0] v,
                                                input logic [CoordW-1:0] lo,
                                                input logic [CoordW-1:0] hi);
    logic [CoordW-1:0] t;
    t = (v < lo) ? lo : v;
    return (t > hi) ? hi : t;
  endfunction

endpackage

### sv/scd_if.sv
// scd_if: valid/ready channel interfaces for command bytes, results and config writes
// depends on scd_pkg

interface scd_in_if import scd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] cmd_byte;
  logic             final_byte;

  modport source (output valid, cmd_byte, final_byte, input ready);
  modport sink (input valid, cmd_byte, final_byte, output ready);
endinterface

interface scd_out_if import scd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              enable_request;
  logic              reset_request;
  logic              coord_valid;
  logic [CoordW-1:0] x_target;
  logic [CoordW-1:0] y_target;
  logic              malformed;

  modport source (output valid, enable_request, reset_request, coord_valid, x_target,
                  y_target, malformed, input ready);
  modport sink (input valid, enable_request, reset_request, coord_valid, x_target,
                y_target, malformed, output ready);
endinterface

interface scd_cfg_if import scd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CoordW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/scd_cfg_regs.sv
// scd_cfg_regs: clamp bound registers written through the config channel
// depends on scd_pkg

module scd_cfg_regs import scd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [CoordW-1:0]  wr_data,
  output bounds_t            bounds
);

  bounds_t bounds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.x_lo <= X_LO_RST;
      bounds_r.x_hi <= X_HI_RST;
      bounds_r.y_lo <= Y_LO_RST;
      bounds_r.y_hi <= Y_HI_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_X_LO: bounds_r.x_lo <= wr_data;
        REG_X_HI: bounds_r.x_hi <= wr_data;
        REG_Y_LO: bounds_r.y_lo <= wr_data;
        REG_Y_HI: bounds_r.y_hi <= wr_data;
        default: ;
      endcase
    end
  end

  assign bounds = bounds_r;

endmodule

### sv/scd_parser.sv
// scd_parser: input register and per-byte command parse state, builds a result
// on the final byte of each command; depends on scd_pkg

module scd_parser import scd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_final,
  input  bounds_t          bounds,
  input  logic             res_ready,
  output logic             res_load,
  output result_t          res
);

  logic             v_r;
  logic [ByteW-1:0] byte_r;
  logic             final_r;
  logic             adv;

  logic [2:0]        phase_r, phase_nxt;
  logic [ByteW-1:0]  lead_r, lead_nxt;
  logic [1:0]        len_r, len_nxt;
  logic [CoordW-1:0] x_r, x_nxt;
  logic [CoordW-1:0] y_r, y_nxt;
  logic              minus_r, minus_nxt;
  logic              started_r, started_nxt;
  logic              stopped_r, stopped_nxt;

  logic [CoordW-1:0] acc, acc_new;
  logic              is_digit, is_c, one, done;

  assign adv      = v_r && (!final_r || res_ready);
  assign in_ready = !v_r || adv;
  assign res_load = adv && final_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      byte_r  <= in_byte;
      final_r <= in_final;
    end
  end

  assign acc      = (phase_r == PH_X) ? x_r : y_r;
  assign is_digit = (byte_r >= CHAR_ZERO) && (byte_r <= CHAR_NINE);

  always_comb begin
    phase_nxt   = phase_r;
    lead_nxt    = lead_r;
    len_nxt     = len_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    minus_nxt   = minus_r;
    started_nxt = started_r;
    stopped_nxt = stopped_r;
    acc_new     = acc;
    unique case (phase_r) inside
      PH_START: begin
        lead_nxt  = byte_r;
        len_nxt   = 2'd1;
        phase_nxt = (byte_r == CHAR_C) ? PH_SKIP : PH_OTHER;
      end
      PH_SKIP: begin
        phase_nxt = PH_X;
      end
      PH_X, PH_Y: begin
        if (byte_r == CHAR_COLON) begin
          acc_new     = minus_r ? (~acc + 16'd1) : acc;
          minus_nxt   = 1'b0;
          started_nxt = 1'b0;
          stopped_nxt = 1'b0;
          phase_nxt   = (phase_r == PH_X) ? PH_Y : PH_DONE;
        end else begin
          if (!stopped_r) begin
            if (is_digit) begin
              // acc * 10 + digit, kept modulo 2^16
              acc_new = {acc[CoordW-4:0], 3'b000} + {acc[CoordW-2:0], 1'b0}
                      + {{(CoordW-4){1'b0}}, byte_r[3:0]};
            end else if (byte_r == CHAR_MINUS && !started_r) begin
              minus_nxt = 1'b1;
            end else begin
              stopped_nxt = 1'b1;
            end
          end
          started_nxt = 1'b1;
        end
        if (phase_r == PH_X) x_nxt = acc_new;
        else y_nxt = acc_new;
      end
      PH_OTHER: begin
        if (len_r < 2'd2) len_nxt = len_r + 2'd1;
      end
      default: ;
    endcase
  end

  // result from the updated state
  assign is_c = (lead_nxt == CHAR_C);
  assign one  = (len_nxt == 2'd1);
  assign done = is_c && (phase_nxt == PH_DONE);

  always_comb begin
    res.enable_request = one && (lead_nxt == CHAR_E);
    res.reset_request  = one && (lead_nxt == CHAR_R);
    res.coord_valid    = done;
    res.x_target       = done ? clamp16(x_nxt, bounds.x_lo, bounds.x_hi) : '0;
    res.y_target       = done ? clamp16(y_nxt, bounds.y_lo, bounds.y_hi) : '0;
    res.malformed      = is_c && !done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      phase_r   <= PH_START;
      lead_r    <= '0;
      len_r     <= '0;
      x_r       <= '0;
      y_r       <= '0;
      minus_r   <= 1'b0;
      started_r <= 1'b0;
      stopped_r <= 1'b0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      lead_r    <= lead_nxt;
      len_r     <= len_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      minus_r   <= minus_nxt;
      started_r <= started_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

### sv/scd_out_reg.sv
// scd_out_reg: result register that holds one result beat until taken
// depends on scd_pkg

module scd_out_reg import scd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    load_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    v_r;
  result_t data_r;

  assign load_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load_ready) begin
      v_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

endmodule

### sv/serial_command_decoder_top.sv
// serial_command_decoder_top: framed ASCII command decoder, top level
// depends on scd_pkg, scd_if, scd_cfg_regs, scd_parser, scd_out_reg
//
//   channel   dir  payload                                          beat when
//   in_bus    in   cmd_byte[7:0], final_byte                        valid & ready
//   out_bus   out  enable/reset_request, coord_valid, x/y_target,   valid & ready
//                  malformed
//   cfg_bus   in   index[1:0], data[15:0]                           valid & ready
//
// one byte per cycle while the result register can take a final byte; a final byte's result
// is decoded out of the input register and lands in the result register when that can take it
// rst_n is synchronous: parse state clears and the bounds return to their defaults
// a stalled out_bus holds the result; bytes keep flowing until a second final byte waits

module serial_command_decoder_top import scd_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  scd_in_if.sink        in_bus,
  scd_out_if.source     out_bus,
  scd_cfg_if.sink       cfg_bus
);

  bounds_t bounds;
  result_t res, out_data;
  logic    res_load, res_ready;

  assign cfg_bus.ready = 1'b1;

  scd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_bus.valid),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .bounds   (bounds)
  );

  scd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_byte   (in_bus.cmd_byte),
    .in_final  (in_bus.final_byte),
    .bounds    (bounds),
    .res_ready (res_ready),
    .res_load  (res_load),
    .res       (res)
  );

  scd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_load),
    .load_data  (res),
    .load_ready (res_ready),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_data   (out_data)
  );

  assign out_bus.enable_request = out_data.enable_request;
  assign out_bus.reset_request  = out_data.reset_request;
  assign out_bus.coord_valid    = out_data.coord_valid;
  assign out_bus.x_target       = out_data.x_target;
  assign out_bus.y_target       = out_data.y_target;
  assign out_bus.malformed      = out_data.malformed;

endmodule
